// ===== rtl/mps_pkg.sv =====
package mps_pkg;

   typedef enum logic [1:0] {
      ST_RUN   = 2'b01,
      ST_SWEEP = 2'b10
   } seq_state_type;

   typedef enum logic [1:0] {
      REG_PATTERN_LENGTH = 2'd0,
      REG_STRIDE_MODE    = 2'd1,
      REG_START_ADDRESS  = 2'd2
   } reg_index_type;

   typedef enum logic [1:0] {
      STRIDE_BYTE  = 2'd0,
      STRIDE_HALF  = 2'd1,
      STRIDE_WORD  = 2'd2,
      STRIDE_DWORD = 2'd3
   } stride_type;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_DATA = 1'b1;

   localparam logic [7:0] PAT_RESET    = 8'h00;
   localparam logic [7:0] MSK_RESET    = 8'hff;
   localparam logic [8:0] LEN_RESET    = 9'd4;
   localparam logic [1:0] STRIDE_RESET = STRIDE_WORD;

   typedef struct packed {
      logic win_shift;
      logic win_clear;
      logic pat_shift;
      logic pat_load;
      logic enable;
   } cell_ctl_type;

endpackage

// ===== rtl/mps_cell.sv =====
module mps_cell
   import mps_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  logic [7:0]   win_nb,
   input  logic [7:0]   pat_nb,
   input  logic [7:0]   msk_nb,
   input  logic [7:0]   ld_pat,
   input  logic [7:0]   ld_msk,
   output logic [7:0]   win_ff,
   output logic [7:0]   pat_ff,
   output logic [7:0]   msk_ff,
   output logic         eq_ff
);

   logic [7:0] win_in;
   logic [7:0] pat_in;
   logic [7:0] msk_in;
   logic       eq_in;

   always_comb begin
      win_in = win_ff;
      eq_in  = eq_ff;
      if (ctl.win_shift) begin
         win_in = ctl.win_clear ? 8'h00 : win_nb;
         eq_in  = !ctl.enable || (((win_nb ^ pat_ff) & msk_ff) == 8'h00);
      end
   end

   always_comb begin
      pat_in = pat_ff;
      msk_in = msk_ff;
      if (ctl.pat_load) begin
         pat_in = ld_pat;
         msk_in = ld_msk;
      end else if (ctl.pat_shift) begin
         pat_in = pat_nb;
         msk_in = msk_nb;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= 8'h00;
         pat_ff <= PAT_RESET;
         msk_ff <= MSK_RESET;
         eq_ff  <= 1'b0;
      end else begin
         win_ff <= win_in;
         pat_ff <= pat_in;
         msk_ff <= msk_in;
         eq_ff  <= eq_in;
      end
   end

endmodule

// ===== rtl/mps_tbl.sv =====
module mps_tbl
   import mps_pkg::*;
#(
   parameter int DEPTH = 256,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_pat,
   input  logic [7:0]    wr_msk,
   input  logic          rd_en,
   input  logic          rd_hit,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_pat_ff,
   output logic [7:0]    rd_msk_ff
);

   logic [7:0]       pat_mem [DEPTH];
   logic [7:0]       msk_mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pat_mem[wr_addr] <= wr_pat;
         msk_mem[wr_addr] <= wr_msk;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // entries never written read as their reset value
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (rd_hit && valid_ff[rd_addr]) begin
            rd_pat_ff <= pat_mem[rd_addr];
            rd_msk_ff <= msk_mem[rd_addr];
         end else begin
            rd_pat_ff <= PAT_RESET;
            rd_msk_ff <= MSK_RESET;
         end
      end
   end

endmodule

// ===== rtl/mps_tree.sv =====
module mps_tree
   import mps_pkg::*;
#(
   parameter int N  = 256,
   parameter int NG = (N + 15) / 16
) (
   input  logic          clock,
   input  logic          load,
   input  logic [N-1:0]  eq,
   output logic [NG-1:0] grp_ff
);

   logic [NG*16-1:0] padded;
   logic [NG-1:0]    grp_in;

   always_comb begin
      padded        = '1;
      padded[N-1:0] = eq;
   end

   for (genvar g = 0; g < NG; g++) begin : g_grp
      assign grp_in[g] = &padded[16*g +: 16];
   end

   always_ff @(posedge clock) begin
      if (load) begin
         grp_ff <= grp_in;
      end
   end

endmodule

// ===== rtl/masked_pattern_scanner_core.sv =====
// channel  direction  transfer when             payload
// req      in         req_valid & !req_stall    req_type, entry, pattern, mask, data, eor
// rsp      out        rsp_valid & !rsp_stall    rsp_match_found, rsp_match_address
// csr      in         psel & penable & pwrite   paddr (8 bytes per register), pwdata
//
// one item per cycle while req_stall is low; s1, s2 and the output register lie between req transfer and rsp_valid
// per-cell compare at the req transfer, then a registered 16-wide and tree
// a pattern_length write realigns the cells: req_stall stays high while the table entries are read and shifted in
// reset: tables read as pattern zero, mask all ones, no realign needed
// rsp_stall backs up the pipe and reaches req_stall in the same cycle
module masked_pattern_scanner_core
   import mps_pkg::*;
#(
   parameter int MAX_PATTERN = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [7:0]  req_entry_index,
   input  logic [7:0]  req_pattern_byte,
   input  logic [7:0]  req_mask_byte,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_region,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_match_found,
   output logic [63:0] rsp_match_address,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);

   localparam int TDEPTH = (MAX_PATTERN > 256) ? 256 : MAX_PATTERN;
   localparam int TAW    = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
   localparam int CW     = ($clog2(MAX_PATTERN + 1) > 9) ? $clog2(MAX_PATTERN + 1) : 9;
   localparam int NG     = (MAX_PATTERN + 15) / 16;

   // configuration
   logic [8:0]    len_ff;
   logic [1:0]    stride_ff;
   logic [63:0]   start_ff;
   logic          csr_wr;
   logic [1:0]    reg_sel;

   // sequencing
   seq_state_type state_ff, state_in;
   logic [CW-1:0] sweep_cnt_ff, sweep_cnt_in;
   logic          rd_pend_ff, rd_pend_in;
   logic          issue;

   // length
   logic [CW-1:0] len_cw;
   logic [CW-1:0] n_eff;
   logic [CW-1:0] nm1;
   logic [CW-1:0] idx_ext;
   logic [CW-1:0] tgt;
   logic          load_hit;

   // handshake and pipe
   logic          acc, acc_data, acc_load;
   logic          move1, move2, free1, free2;
   logic          s1_valid_ff, s1_valid_in;
   logic          s1_gate_ff;
   logic [63:0]   s1_first_ff;
   logic          s2_valid_ff, s2_valid_in;
   logic          s2_gate_ff;
   logic [63:0]   s2_addr_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          found_ff;
   logic [63:0]   addr_ff;
   logic          found_in;

   // offset
   logic [63:0]   offset_ff, offset_in;
   logic [64:0]   diff;
   logic [2:0]    align_mask;
   logic          gate_in;

   // cells
   logic [7:0]         win_w [MAX_PATTERN];
   logic [7:0]         pat_w [MAX_PATTERN];
   logic [7:0]         msk_w [MAX_PATTERN];
   logic [MAX_PATTERN-1:0] eq_w;
   cell_ctl_type       ctl_w [MAX_PATTERN];
   logic [7:0]         tbl_pat, tbl_msk;
   logic [NG-1:0]      grp_w;

   // ---------------- configuration port ----------------
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign reg_sel = paddr[4:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff    <= LEN_RESET;
         stride_ff <= STRIDE_RESET;
         start_ff  <= 64'd0;
      end else if (csr_wr) begin
         case (reg_sel)
            REG_PATTERN_LENGTH: len_ff    <= pwdata[8:0];
            REG_STRIDE_MODE:    stride_ff <= pwdata[1:0];
            REG_START_ADDRESS:  start_ff  <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_PATTERN_LENGTH: prdata = {55'd0, len_ff};
         REG_STRIDE_MODE:    prdata = {62'd0, stride_ff};
         REG_START_ADDRESS:  prdata = start_ff;
         default:            prdata = 64'd0;
      endcase
   end

   // ---------------- effective length ----------------
   assign len_cw  = CW'(len_ff);
   assign idx_ext = CW'(req_entry_index);

   always_comb begin
      if (len_ff == 9'd0) begin
         n_eff = CW'(1);
      end else if (len_cw > CW'(MAX_PATTERN)) begin
         n_eff = CW'(MAX_PATTERN);
      end else begin
         n_eff = len_cw;
      end
   end

   assign nm1 = n_eff - CW'(1);

   // ---------------- handshake ----------------
   assign move2     = s2_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign free2     = !s2_valid_ff || move2;
   assign move1     = s1_valid_ff && free2;
   assign free1     = !s1_valid_ff || move1;
   assign req_stall = (state_ff != ST_RUN) || !free1;
   assign acc       = req_valid && !req_stall;
   assign acc_data  = acc && (req_type == REQ_DATA);
   assign acc_load  = acc && (req_type == REQ_LOAD);

   // loaded entry i sits in cell n-1-i
   assign load_hit = acc_load && (idx_ext <= nm1);
   assign tgt      = nm1 - idx_ext;

   // ---------------- realign sequencer ----------------
   assign issue = (state_ff == ST_SWEEP) && (sweep_cnt_ff < n_eff);

   always_comb begin
      state_in     = state_ff;
      sweep_cnt_in = sweep_cnt_ff;
      rd_pend_in   = issue;
      if (csr_wr && (reg_sel == REG_PATTERN_LENGTH)) begin
         state_in     = ST_SWEEP;
         sweep_cnt_in = '0;
         rd_pend_in   = 1'b0;
      end else begin
         case (state_ff)
            ST_RUN: begin
               rd_pend_in = 1'b0;
            end
            ST_SWEEP: begin
               if (issue) begin
                  sweep_cnt_in = sweep_cnt_ff + CW'(1);
               end else if (!rd_pend_ff) begin
                  state_in = ST_RUN;
               end
            end
            default: begin
               state_in   = ST_RUN;
               rd_pend_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         sweep_cnt_ff <= '0;
         rd_pend_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_cnt_ff <= sweep_cnt_in;
         rd_pend_ff   <= rd_pend_in;
      end
   end

   mps_tbl #(
      .DEPTH (TDEPTH),
      .AW    (TAW)
   ) u_tbl (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (acc_load && (idx_ext < CW'(TDEPTH))),
      .wr_addr   (req_entry_index[TAW-1:0]),
      .wr_pat    (req_pattern_byte),
      .wr_msk    (req_mask_byte),
      .rd_en     (issue),
      .rd_hit    (sweep_cnt_ff < CW'(TDEPTH)),
      .rd_addr   (sweep_cnt_ff[TAW-1:0]),
      .rd_pat_ff (tbl_pat),
      .rd_msk_ff (tbl_msk)
   );

   // ---------------- cell row ----------------
   for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
      logic [7:0] win_nb, pat_nb, msk_nb;

      assign ctl_w[j] = '{
         win_shift: acc_data,
         win_clear: req_end_of_region,
         pat_shift: rd_pend_ff,
         pat_load:  load_hit && (tgt == CW'(j)),
         enable:    (CW'(j) <= nm1)
      };

      if (j == 0) begin : g_head
         assign win_nb = req_data_byte;
         assign pat_nb = tbl_pat;
         assign msk_nb = tbl_msk;
      end else begin : g_body
         assign win_nb = win_w[j-1];
         assign pat_nb = pat_w[j-1];
         assign msk_nb = msk_w[j-1];
      end

      mps_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .ctl    (ctl_w[j]),
         .win_nb (win_nb),
         .pat_nb (pat_nb),
         .msk_nb (msk_nb),
         .ld_pat (req_pattern_byte),
         .ld_msk (req_mask_byte),
         .win_ff (win_w[j]),
         .pat_ff (pat_w[j]),
         .msk_ff (msk_w[j]),
         .eq_ff  (eq_w[j])
      );
   end

   mps_tree #(
      .N  (MAX_PATTERN),
      .NG (NG)
   ) u_tree (
      .clock  (clock),
      .load   (move1),
      .eq     (eq_w),
      .grp_ff (grp_w)
   );

   // ---------------- offset and window start ----------------
   assign diff = {1'b0, offset_ff} - 65'(nm1);

   always_comb begin
      case (stride_ff)
         STRIDE_BYTE:  align_mask = 3'b000;
         STRIDE_HALF:  align_mask = 3'b001;
         STRIDE_WORD:  align_mask = 3'b011;
         STRIDE_DWORD: align_mask = 3'b111;
         default:      align_mask = 3'b000;
      endcase
   end

   assign gate_in   = acc_data && !diff[64] && ((diff[2:0] & align_mask) == 3'b000);
   assign offset_in = req_end_of_region ? 64'd0 : offset_ff + 64'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= 64'd0;
      end else if (acc_data) begin
         offset_ff <= offset_in;
      end
   end

   // ---------------- result pipe ----------------
   assign s1_valid_in  = acc ? 1'b1 : (move1 ? 1'b0 : s1_valid_ff);
   assign s2_valid_in  = move1 ? 1'b1 : (move2 ? 1'b0 : s2_valid_ff);
   assign rsp_valid_in = move2 ? 1'b1 : ((rsp_valid_ff && !rsp_stall) ? 1'b0 : rsp_valid_ff);
   assign found_in     = s2_gate_ff && (&grp_w);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         s1_gate_ff  <= gate_in;
         s1_first_ff <= diff[63:0];
      end
      if (move1) begin
         s2_gate_ff <= s1_gate_ff;
         s2_addr_ff <= start_ff + s1_first_ff;
      end
      if (move2) begin
         found_ff <= found_in;
         addr_ff  <= found_in ? s2_addr_ff : 64'd0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_match_found   = found_ff;
   assign rsp_match_address = addr_ff;

   // ---------------- checks ----------------
   a_eor_restart: assert property (@(posedge clock) disable iff (reset)
      acc_data && req_end_of_region |=> offset_ff == 64'd0)
      else $error("offset not restarted after end of region");

   a_sweep_blocks: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SWEEP |-> req_stall)
      else $error("request taken during realign");

   a_read_from_sweep: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> $past(state_ff == ST_SWEEP))
      else $error("table read outside realign");

   a_out_load: assert property (@(posedge clock) disable iff (reset)
      move2 |=> rsp_valid_ff)
      else $error("result lost on output load");

endmodule
